// ===== hw/rtl/aabb_affine_transform_macros.svh =====
// ----------------------------------------------------------------------------
// aabb_affine_transform_macros.svh
// Assertion helpers shared by the box transform RTL.
// ----------------------------------------------------------------------------
`ifndef AABB_AFFINE_TRANSFORM_MACROS_SVH
`define AABB_AFFINE_TRANSFORM_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define AAT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("aabb_affine_transform: same-cycle check failed");

// Next-cycle implication, disabled while reset is low
`define AAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("aabb_affine_transform: next-cycle check failed");

`endif

// ===== hw/rtl/aat_pkg.sv =====
// ----------------------------------------------------------------------------
// aat_pkg
// Shared types and constants of the box transform block.
// ----------------------------------------------------------------------------
package aat_pkg;

    // Width of every coefficient, translation and box field
    localparam int FIELD_W  = 32;
    // Spatial axes (rows of the matrix, columns of the linear part)
    localparam int NUM_AXES = 3;
    // Width of the configuration register index
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOX_MIN_X = 3'd0,
        CFG_BOX_MIN_Y = 3'd1,
        CFG_BOX_MIN_Z = 3'd2,
        CFG_BOX_MAX_X = 3'd3,
        CFG_BOX_MAX_Y = 3'd4,
        CFG_BOX_MAX_Z = 3'd5
    } t_cfg_idx;

    // Load enables of the four pipeline stages
    typedef struct packed {
        logic en_mul;
        logic en_sel;
        logic en_sum;
        logic en_out;
    } t_stage_ctrl;

endpackage

// ===== hw/rtl/aat_row.sv =====
// ----------------------------------------------------------------------------
// aat_row
// One world axis: products, per-column min/max, sum with translation, clamp.
// ----------------------------------------------------------------------------
module aat_row #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                                   i_clk,
    input  aat_pkg::t_stage_ctrl                   i_ctrl,
    input  logic signed [aat_pkg::FIELD_W-1:0]     i_coef   [aat_pkg::NUM_AXES],
    input  logic signed [aat_pkg::FIELD_W-1:0]     i_trans,
    input  logic signed [aat_pkg::FIELD_W-1:0]     i_box_lo [aat_pkg::NUM_AXES],
    input  logic signed [aat_pkg::FIELD_W-1:0]     i_box_hi [aat_pkg::NUM_AXES],
    input  logic                                   i_empty,
    output logic        [aat_pkg::FIELD_W-1:0]     o_min,
    output logic        [aat_pkg::FIELD_W-1:0]     o_max,
    output logic                                   o_sat
);

    localparam int FW    = aat_pkg::FIELD_W;
    localparam int NA    = aat_pkg::NUM_AXES;
    localparam int PROD_W = 2 * FW;
    localparam int SH_W  = PROD_W - FRAC_BITS;
    localparam int SUM_W = ((SH_W + 2) > (COORD_WIDTH + 1)) ? (SH_W + 2) : (COORD_WIDTH + 1);

    localparam logic signed [SUM_W-1:0] C_HI =
        {{(SUM_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] C_LO = ~C_HI;

    // Stage 1: exact products against both box extremes
    logic signed [PROD_W-1:0] r_prod_lo [NA];
    logic signed [PROD_W-1:0] r_prod_hi [NA];
    logic signed [FW-1:0]     r_trans1;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_mul) begin
            for (int c = 0; c < NA; c++) begin
                r_prod_lo[c] <= i_coef[c] * i_box_lo[c];
                r_prod_hi[c] <= i_coef[c] * i_box_hi[c];
            end
            r_trans1 <= i_trans;
        end
    end

    // Stage 2: floor the products, pick smaller and larger per column (zero for an empty box)
    logic signed [SH_W-1:0] n_sel_min [NA];
    logic signed [SH_W-1:0] n_sel_max [NA];
    logic signed [SH_W-1:0] r_sel_min [NA];
    logic signed [SH_W-1:0] r_sel_max [NA];
    logic signed [FW-1:0]   r_trans2;

    always_comb begin
        logic signed [PROD_W-1:0] sa;
        logic signed [PROD_W-1:0] sb;
        for (int c = 0; c < NA; c++) begin
            sa = r_prod_lo[c] >>> FRAC_BITS;
            sb = r_prod_hi[c] >>> FRAC_BITS;
            if (i_empty) begin
                n_sel_min[c] = '0;
                n_sel_max[c] = '0;
            end else if (sa < sb) begin
                n_sel_min[c] = sa[SH_W-1:0];
                n_sel_max[c] = sb[SH_W-1:0];
            end else begin
                n_sel_min[c] = sb[SH_W-1:0];
                n_sel_max[c] = sa[SH_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_sel) begin
            r_sel_min <= n_sel_min;
            r_sel_max <= n_sel_max;
            r_trans2  <= r_trans1;
        end
    end

    // Stage 3: add the three column terms and the translation
    logic signed [SUM_W-1:0] n_sum_min;
    logic signed [SUM_W-1:0] n_sum_max;
    logic signed [SUM_W-1:0] r_sum_min;
    logic signed [SUM_W-1:0] r_sum_max;

    always_comb begin
        n_sum_min = {{(SUM_W - FW){r_trans2[FW-1]}}, r_trans2};
        n_sum_max = {{(SUM_W - FW){r_trans2[FW-1]}}, r_trans2};
        for (int c = 0; c < NA; c++) begin
            n_sum_min = n_sum_min + {{(SUM_W - SH_W){r_sel_min[c][SH_W-1]}}, r_sel_min[c]};
            n_sum_max = n_sum_max + {{(SUM_W - SH_W){r_sel_max[c][SH_W-1]}}, r_sel_max[c]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_sum) begin
            r_sum_min <= n_sum_min;
            r_sum_max <= n_sum_max;
        end
    end

    // Stage 4: clamp to the coordinate range and flag any clamp
    logic signed [SUM_W-1:0] n_clp_min;
    logic signed [SUM_W-1:0] n_clp_max;
    logic                    n_sat;

    always_comb begin
        n_sat     = 1'b0;
        n_clp_min = r_sum_min;
        n_clp_max = r_sum_max;
        if (r_sum_min > C_HI) begin
            n_clp_min = C_HI;
            n_sat     = 1'b1;
        end else if (r_sum_min < C_LO) begin
            n_clp_min = C_LO;
            n_sat     = 1'b1;
        end
        if (r_sum_max > C_HI) begin
            n_clp_max = C_HI;
            n_sat     = 1'b1;
        end else if (r_sum_max < C_LO) begin
            n_clp_max = C_LO;
            n_sat     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_out) begin
            o_min <= n_clp_min[FW-1:0];
            o_max <= n_clp_max[FW-1:0];
            o_sat <= n_sat;
        end
    end

endmodule

// ===== hw/rtl/aabb_affine_transform.sv =====
// ----------------------------------------------------------------------------
// aabb_affine_transform
// World-space bounding box of a fixed local box under a 3x4 affine matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Write the local box (min x/y/z, max x/y/z, signed Q16.16) through the
//   configuration port while the block is idle. Each input word on s_axis is
//   one 3x4 matrix; each output word on m_axis is the enclosing world box,
//   with tuser set when any component was clamped to the coordinate range.
//   An empty local box (some min above its max) yields the translation for
//   both corners.
// Pipeline: an accepted matrix passes the multiply, select, sum and clamp registers in turn.
// Throughput: one word per cycle while m_axis_tready is high; stage 1
//   holds 18 32x32 multipliers (one per coefficient and box extreme), and
//   each later stage is one compare, one four-term add or one clamp.
// Reset: the box registers clear to zero and the pipeline empties.
// Stall: each stage holds while the one after it is full and blocked;
//   s_axis_tready drops only when all four stages hold words.
// ----------------------------------------------------------------------------
`include "aabb_affine_transform_macros.svh"

module aabb_affine_transform #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_wen,
    input  logic [aat_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [aat_pkg::FIELD_W-1:0]       i_cfg_wdata,
    // Input matrix stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // row0_col0, row0_col1, row0_col2, row0_col3, row1_col0 .. row1_col3,
    // row2_col0 .. row2_col3 (32 bits each, lowest first)
    input  logic [12*aat_pkg::FIELD_W-1:0]    s_axis_tdata,
    // Output box stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // world_min_x, world_min_y, world_min_z, world_max_x, world_max_y,
    // world_max_z (32 bits each, lowest first)
    output logic [6*aat_pkg::FIELD_W-1:0]     m_axis_tdata,
    // saturated
    output logic                              m_axis_tuser
);

    localparam int FW = aat_pkg::FIELD_W;
    localparam int NA = aat_pkg::NUM_AXES;
    localparam int NUM_STAGES = 4;

    // Hold the local box
    logic signed [FW-1:0] r_box_lo [NA];
    logic signed [FW-1:0] r_box_hi [NA];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NA; a++) begin
                r_box_lo[a] <= '0;
                r_box_hi[a] <= '0;
            end
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                aat_pkg::CFG_BOX_MIN_X: r_box_lo[0] <= i_cfg_wdata;
                aat_pkg::CFG_BOX_MIN_Y: r_box_lo[1] <= i_cfg_wdata;
                aat_pkg::CFG_BOX_MIN_Z: r_box_lo[2] <= i_cfg_wdata;
                aat_pkg::CFG_BOX_MAX_X: r_box_hi[0] <= i_cfg_wdata;
                aat_pkg::CFG_BOX_MAX_Y: r_box_hi[1] <= i_cfg_wdata;
                aat_pkg::CFG_BOX_MAX_Z: r_box_hi[2] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Flag an empty box
    logic w_empty;

    always_comb begin
        w_empty = 1'b0;
        for (int a = 0; a < NA; a++) begin
            if (r_box_lo[a] > r_box_hi[a]) begin
                w_empty = 1'b1;
            end
        end
    end

    // Advance each stage when it is empty or its successor advances
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] w_rdy;
    aat_pkg::t_stage_ctrl  w_ctrl;

    always_comb begin
        w_rdy[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
        w_ctrl.en_mul = w_rdy[0];
        w_ctrl.en_sel = w_rdy[1];
        w_ctrl.en_sum = w_rdy[2];
        w_ctrl.en_out = w_rdy[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign s_axis_tready = w_rdy[0];
    assign m_axis_tvalid = r_vld[NUM_STAGES-1];

    // One datapath per world axis
    logic [FW-1:0] w_min [NA];
    logic [FW-1:0] w_max [NA];
    logic [NA-1:0] w_sat;

    for (genvar r = 0; r < NA; r++) begin : g_row
        logic signed [FW-1:0] w_coef [NA];

        for (genvar c = 0; c < NA; c++) begin : g_col
            assign w_coef[c] = s_axis_tdata[(r*4 + c)*FW +: FW];
        end

        aat_row #(
            .FRAC_BITS   (FRAC_BITS),
            .COORD_WIDTH (COORD_WIDTH)
        ) u_row (
            .i_clk    (i_clk),
            .i_ctrl   (w_ctrl),
            .i_coef   (w_coef),
            .i_trans  (s_axis_tdata[(r*4 + 3)*FW +: FW]),
            .i_box_lo (r_box_lo),
            .i_box_hi (r_box_hi),
            .i_empty  (w_empty),
            .o_min    (w_min[r]),
            .o_max    (w_max[r]),
            .o_sat    (w_sat[r])
        );

        assign m_axis_tdata[r*FW +: FW]        = w_min[r];
        assign m_axis_tdata[(NA + r)*FW +: FW] = w_max[r];
    end

    assign m_axis_tuser = |w_sat;

    // Pipeline checks
    `AAT_ASSERT_NEXT(a_accept_fills_s1, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_vld[0])
    `AAT_ASSERT_NEXT(a_s3_reaches_out, i_clk, i_rst_n, r_vld[2] && w_rdy[3], m_axis_tvalid)
    `AAT_ASSERT_IMPL(a_stall_only_full, i_clk, i_rst_n, !s_axis_tready, &r_vld)

endmodule
